// ===== rtl/core/cpr_pkg.sv =====
package cpr_pkg;

  // Width of the duration registers
  localparam int unsigned CfgW = 20;

  // Default width of the per-mode millisecond counter
  localparam int unsigned TimeBitsDef = 20;

  // Register index width and reset values
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgW-1:0] CompressMsRst   = CfgW'(120000);
  localparam logic [CfgW-1:0] ReevaluateMsRst = CfgW'(10000);
  localparam logic [CfgW-1:0] ConfirmMsRst    = CfgW'(10000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COMPRESS   = 2'd0,
    CFG_REEVALUATE = 2'd1,
    CFG_CONFIRM    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_MONITOR  = 2'd0,
    MODE_COMPRESS = 2'd1,
    MODE_REEVAL   = 2'd2,
    MODE_CONFIRM  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_CONFIRM = 2'd1,
    REQ_DISMISS = 2'd2,
    REQ_RETRY   = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic       pulse_present;
    logic       sensor_failed;
  } cpr_in_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       silenced;
    logic       changed;
  } cpr_out_t;

endpackage

// ===== rtl/core/cpr_cycle_controller_unit.sv =====
// A result is registered in the output register, where it appears in the cycle after its input is taken.
// Throughput: one transaction per cycle unless a held result stalls the input; the
// combinational decision path from the mode/counter registers to the result register allows it.
// Reset (rst_ni low, asynchronous): mode monitoring, counter zero, prompt not silenced,
// durations at their defaults, output register empty.
module cpr_cycle_controller_unit #(
  parameter int unsigned TIME_BITS = cpr_pkg::TimeBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [cpr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cpr_pkg::CfgW-1:0]       cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cpr_pkg::cpr_in_t               in_data_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cpr_pkg::cpr_out_t              out_data_o
);

  localparam int unsigned CmpW = (TIME_BITS > cpr_pkg::CfgW) ? TIME_BITS : cpr_pkg::CfgW;
  localparam logic [TIME_BITS-1:0] CntMax = {TIME_BITS{1'b1}};

  logic [cpr_pkg::CfgW-1:0] compress_ms_q, reevaluate_ms_q, confirm_ms_q;
  cpr_pkg::mode_e           mode_q, mode_d;
  logic [TIME_BITS-1:0]     cnt_q, cnt_d, cnt_inc;
  logic                     silenced_q, silenced_d;
  logic                     changed;
  logic                     out_valid_q;
  cpr_pkg::cpr_out_t        out_data_q;
  logic                     in_accept;
  logic                     compress_done, reeval_done, confirm_done;
  cpr_pkg::req_e            req;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign req        = cpr_pkg::req_e'(in_data_i.req_type);

  // Write the duration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compress_ms_q   <= cpr_pkg::CompressMsRst;
      reevaluate_ms_q <= cpr_pkg::ReevaluateMsRst;
      confirm_ms_q    <= cpr_pkg::ConfirmMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cpr_pkg::CFG_COMPRESS:   compress_ms_q   <= cfg_wdata_i;
        cpr_pkg::CFG_REEVALUATE: reevaluate_ms_q <= cfg_wdata_i;
        cpr_pkg::CFG_CONFIRM:    confirm_ms_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the counter, saturating, and compare against the durations
  assign cnt_inc       = (cnt_q == CntMax) ? cnt_q : cnt_q + TIME_BITS'(1);
  assign compress_done = CmpW'(cnt_inc) >= CmpW'(compress_ms_q);
  assign reeval_done   = CmpW'(cnt_inc) >= CmpW'(reevaluate_ms_q);
  assign confirm_done  = CmpW'(cnt_inc) >= CmpW'(confirm_ms_q);

  // Decide the next mode for the presented transaction
  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    silenced_d = silenced_q;
    changed    = 1'b0;
    unique case (req)
      cpr_pkg::REQ_TICK: begin
        cnt_d = cnt_inc;
        unique case (mode_q)
          cpr_pkg::MODE_MONITOR: begin
            if (!in_data_i.pulse_present && !silenced_q) begin
              mode_d  = in_data_i.sensor_failed ? cpr_pkg::MODE_CONFIRM
                                                : cpr_pkg::MODE_COMPRESS;
              changed = 1'b1;
            end
          end
          cpr_pkg::MODE_COMPRESS: begin
            if (compress_done) begin
              mode_d  = cpr_pkg::MODE_REEVAL;
              changed = 1'b1;
            end
          end
          cpr_pkg::MODE_REEVAL: begin
            if (reeval_done) begin
              changed = 1'b1;
              priority if (in_data_i.pulse_present) begin
                mode_d = cpr_pkg::MODE_MONITOR;
              end else if (!silenced_q && in_data_i.sensor_failed) begin
                mode_d = cpr_pkg::MODE_CONFIRM;
              end else begin
                mode_d = cpr_pkg::MODE_COMPRESS;
              end
            end
          end
          default: begin
            if (confirm_done) begin
              mode_d  = cpr_pkg::MODE_COMPRESS;
              changed = 1'b1;
            end
          end
        endcase
      end
      cpr_pkg::REQ_CONFIRM: begin
        if (mode_q == cpr_pkg::MODE_CONFIRM) begin
          mode_d  = cpr_pkg::MODE_COMPRESS;
          changed = 1'b1;
        end
      end
      cpr_pkg::REQ_DISMISS: begin
        if (mode_q == cpr_pkg::MODE_CONFIRM) begin
          mode_d     = cpr_pkg::MODE_MONITOR;
          silenced_d = 1'b1;
          changed    = 1'b1;
        end
      end
      default: begin
        silenced_d = 1'b0;
      end
    endcase
    // every transition restarts the counter
    if (changed) begin
      cnt_d = '0;
    end
  end

  // Commit state on an accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= cpr_pkg::MODE_MONITOR;
      cnt_q      <= '0;
      silenced_q <= 1'b0;
    end else if (in_accept) begin
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      silenced_q <= silenced_d;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q.mode     <= mode_d;
      out_data_q.silenced <= silenced_d;
      out_data_q.changed  <= changed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Result register mirrors the committed mode and silence flag
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o && (out_data_o.mode == mode_q) &&
                  (out_data_o.silenced == silenced_q))
    else $error("result does not match committed state");

  // Retry always clears the silence flag
  a_retry_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (req == cpr_pkg::REQ_RETRY) |=> !silenced_q)
    else $error("retry did not clear silence");

  // A mode change restarts the counter
  a_change_clears_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (mode_d != mode_q) |=> (cnt_q == '0))
    else $error("counter not cleared on mode change");

endmodule
